/* hw/rtl/multi_policy_process_scheduler_core_defines.svh */
`ifndef MULTI_POLICY_PROCESS_SCHEDULER_CORE_DEFINES_SVH
`define MULTI_POLICY_PROCESS_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk with reset masked.
`define MPPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mpps_pkg.sv */
`timescale 1ns / 1ps
package mpps_pkg;

    localparam int MODE_W   = 3;
    localparam int ARG_W    = 8;
    localparam int NEXT_W   = 3;
    localparam int POLICY_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_YIELD        = 3'd0,
        MODE_EXIT         = 3'd1,
        MODE_SET_PRIORITY = 3'd2,
        MODE_SET_SHARES   = 3'd3,
        MODE_CLOCK        = 3'd4
    } mode_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_RR     = 2'd0,
        POL_LOWEST = 2'd1,
        POL_PRIO   = 2'd2,
        POL_SHARE  = 2'd3
    } policy_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXIT_RD,
        ST_EXIT_WR,
        ST_SET_RD,
        ST_SET_WR,
        ST_SCAN,
        ST_DECIDE,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             runnable;
        logic [ARG_W-1:0] prio;
        logic [ARG_W-1:0] share;
        logic [ARG_W-1:0] count;
    } slot_entry_t;

    localparam slot_entry_t SLOT_RESET = '{
        runnable: 1'b1,
        prio:     '0,
        share:    '0,
        count:    '0
    };

    typedef struct packed {
        logic found;
        logic clear_all;
        logic bump;
    } scan_flags_t;

endpackage

/* hw/rtl/mpps_req_if.sv */
`timescale 1ns / 1ps
interface mpps_req_if;
    import mpps_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ARG_W-1:0]  argument;

    modport source (output valid, output mode, output argument, input ready);
    modport sink (input valid, input mode, input argument, output ready);
endinterface

/* hw/rtl/mpps_rsp_if.sv */
`timescale 1ns / 1ps
interface mpps_rsp_if;
    import mpps_pkg::*;

    logic              valid;
    logic              ready;
    logic [NEXT_W-1:0] next_process;
    logic              none_runnable;

    modport source (output valid, output next_process, output none_runnable, input ready);
    modport sink (input valid, input next_process, input none_runnable, output ready);
endinterface

/* hw/rtl/mpps_cfg_if.sv */
`timescale 1ns / 1ps
interface mpps_cfg_if;
    import mpps_pkg::*;

    logic                valid;
    logic                ready;
    logic [POLICY_W-1:0] scheduling_policy;

    modport source (output valid, output scheduling_policy, input ready);
    modport sink (input valid, input scheduling_policy, output ready);
endinterface

/* hw/rtl/mpps_slot_mem.sv */
`timescale 1ns / 1ps
module mpps_slot_mem #(
    parameter int NUM_SLOTS = 4,
    parameter int IDX_W     = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output mpps_pkg::slot_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  mpps_pkg::slot_entry_t wr_data
);
    import mpps_pkg::*;

    slot_entry_t          mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    slot_entry_t          rd_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // entries never written read as their reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_reg : SLOT_RESET;

endmodule

/* hw/rtl/mpps_scan.sv */
`timescale 1ns / 1ps
module mpps_scan #(
    parameter int IDX_W = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  en,
    input  mpps_pkg::policy_t     policy,
    input  logic [IDX_W-1:0]      cur_idx,
    input  logic [IDX_W-1:0]      idx,
    input  mpps_pkg::slot_entry_t entry,
    output logic [IDX_W-1:0]      pick_idx,
    output mpps_pkg::scan_flags_t flags
);
    import mpps_pkg::*;

    logic             any_run_reg, any_run_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic             rr_hi_found_reg, rr_hi_found_next;
    logic [IDX_W-1:0] rr_hi_reg, rr_hi_next;
    logic             pr_found_reg, pr_found_next;
    logic [ARG_W-1:0] pr_best_reg, pr_best_next;
    logic [IDX_W-1:0] pr_lo_reg, pr_lo_next;
    logic             pr_hi_found_reg, pr_hi_found_next;
    logic [IDX_W-1:0] pr_hi_reg, pr_hi_next;
    logic             zero_found_reg, zero_found_next;
    logic [IDX_W-1:0] zero_reg, zero_next;
    logic             elig_found_reg, elig_found_next;
    logic [IDX_W-1:0] elig_reg, elig_next;
    logic             after_cur;

    assign after_cur = (idx > cur_idx);

    always_comb
    begin
        any_run_next     = any_run_reg;
        first_next       = first_reg;
        rr_hi_found_next = rr_hi_found_reg;
        rr_hi_next       = rr_hi_reg;
        pr_found_next    = pr_found_reg;
        pr_best_next     = pr_best_reg;
        pr_lo_next       = pr_lo_reg;
        pr_hi_found_next = pr_hi_found_reg;
        pr_hi_next       = pr_hi_reg;
        zero_found_next  = zero_found_reg;
        zero_next        = zero_reg;
        elig_found_next  = elig_found_reg;
        elig_next        = elig_reg;
        if (start)
        begin
            any_run_next     = 1'b0;
            rr_hi_found_next = 1'b0;
            pr_found_next    = 1'b0;
            pr_hi_found_next = 1'b0;
            zero_found_next  = 1'b0;
            elig_found_next  = 1'b0;
        end
        else if (en && entry.runnable)
        begin
            if (!any_run_reg)
            begin
                any_run_next = 1'b1;
                first_next   = idx;
            end
            if (!rr_hi_found_reg && after_cur)
            begin
                rr_hi_found_next = 1'b1;
                rr_hi_next       = idx;
            end
            // new minimum restarts the tie tracking
            if (!pr_found_reg || entry.prio < pr_best_reg)
            begin
                pr_found_next    = 1'b1;
                pr_best_next     = entry.prio;
                pr_lo_next       = idx;
                pr_hi_found_next = after_cur;
                pr_hi_next       = idx;
            end
            else if (entry.prio == pr_best_reg && !pr_hi_found_reg && after_cur)
            begin
                pr_hi_found_next = 1'b1;
                pr_hi_next       = idx;
            end
            if (!zero_found_reg && entry.share == '0)
            begin
                zero_found_next = 1'b1;
                zero_next       = idx;
            end
            if (!elig_found_reg && entry.count < entry.share)
            begin
                elig_found_next = 1'b1;
                elig_next       = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_run_reg     <= 1'b0;
            rr_hi_found_reg <= 1'b0;
            pr_found_reg    <= 1'b0;
            pr_hi_found_reg <= 1'b0;
            zero_found_reg  <= 1'b0;
            elig_found_reg  <= 1'b0;
        end
        else
        begin
            any_run_reg     <= any_run_next;
            rr_hi_found_reg <= rr_hi_found_next;
            pr_found_reg    <= pr_found_next;
            pr_hi_found_reg <= pr_hi_found_next;
            zero_found_reg  <= zero_found_next;
            elig_found_reg  <= elig_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg   <= first_next;
        rr_hi_reg   <= rr_hi_next;
        pr_best_reg <= pr_best_next;
        pr_lo_reg   <= pr_lo_next;
        pr_hi_reg   <= pr_hi_next;
        zero_reg    <= zero_next;
        elig_reg    <= elig_next;
    end

    always_comb
    begin
        flags    = '0;
        pick_idx = first_reg;
        unique case (policy)
            POL_RR:
            begin
                flags.found = any_run_reg;
                pick_idx    = rr_hi_found_reg ? rr_hi_reg : first_reg;
            end
            POL_LOWEST:
            begin
                flags.found = any_run_reg;
                pick_idx    = first_reg;
            end
            POL_PRIO:
            begin
                flags.found = pr_found_reg;
                pick_idx    = pr_hi_found_reg ? pr_hi_reg : pr_lo_reg;
            end
            POL_SHARE:
            begin
                if (zero_found_reg)
                begin
                    flags.found = 1'b1;
                    pick_idx    = zero_reg;
                end
                else if (elig_found_reg)
                begin
                    flags.found = 1'b1;
                    flags.bump  = 1'b1;
                    pick_idx    = elig_reg;
                end
                else
                begin
                    // all runnable shares are nonzero, so the first one wins after clear
                    flags.found     = any_run_reg;
                    flags.clear_all = 1'b1;
                    pick_idx        = first_reg;
                end
            end
            default:
            begin
                flags.found = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/multi_policy_process_scheduler_core.sv */
`timescale 1ns / 1ps
// Process scheduler over NUM_SLOTS slots, numbered 1..NUM_SLOTS.
// req: one event word (mode, argument). rsp: one result word per event
// (next_process, none_runnable). cfg: writes the scheduling policy; always
// ready; the user must write it only while no event is in flight, and the
// block does not enforce it. Slot state (runnable, priority, shares, share
// count) lives in a one-port-read, one-port-write table with a registered read.
// Yield, clock tick and exit events walk over it, one entry per cycle; set
// priority and set shares read-modify-write the current slot's entry.
// Exit clears the current slot's runnable bit before its walk; proportional
// share adds a count bump of the picked slot or a count clear sweep.
// One event is in flight at a time; req.ready returns in the cycle the result
// moves into the output register.
// rsp is a holding register: a stalled receiver keeps the word, and the next
// event is accepted meanwhile but cannot finish until the word is taken.
// Reset: all slots runnable, tables zero, current slot 1, policy proportional
// share. No clearing pass is needed; entries never written read as reset values.
`include "multi_policy_process_scheduler_core_defines.svh"
module multi_policy_process_scheduler_core #(
    parameter int NUM_SLOTS = 4
) (
    input logic    clk,
    input logic    rst_n,
    mpps_cfg_if.sink   cfg,
    mpps_req_if.sink   req,
    mpps_rsp_if.source rsp
);
    import mpps_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    state_t            st_reg, st_next;
    policy_t           policy_reg;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [ARG_W-1:0]  arg_reg, arg_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic              issuing_reg, issuing_next;
    logic              rd_pend_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              res_none_reg, res_none_next;
    logic              out_valid_reg, out_valid_next;
    logic [NEXT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_none_reg, out_none_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    slot_entry_t       rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    slot_entry_t       wr_data;

    logic              scan_start;
    logic              scan_en;
    logic [IDX_W-1:0]  pick_idx;
    scan_flags_t       flags;
    logic              last_data;

    mpps_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mpps_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .en       (scan_en),
        .policy   (policy_reg),
        .cur_idx  (cur_reg),
        .idx      (rd_idx_reg),
        .entry    (rd_data),
        .pick_idx (pick_idx),
        .flags    (flags)
    );

    assign cfg.ready         = 1'b1;
    assign req.ready         = (st_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.next_process  = out_slot_reg;
    assign rsp.none_runnable = out_none_reg;

    assign last_data = rd_pend_reg && (rd_idx_reg == last_reg);

    always_comb
    begin
        st_next        = st_reg;
        cur_next       = cur_reg;
        mode_next      = mode_reg;
        arg_next       = arg_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        issuing_next   = issuing_reg;
        res_none_next  = res_none_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_slot_next  = out_slot_reg;
        out_none_next  = out_none_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = rd_idx_reg;
        wr_data        = rd_data;
        scan_start     = 1'b0;
        scan_en        = 1'b0;

        // table walk shared by the scan and update passes
        if (issuing_reg && (st_reg == ST_SCAN || st_reg == ST_UPD))
        begin
            rd_en = 1'b1;
            if (idx_reg == last_reg)
            begin
                issuing_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next = req.mode;
                    arg_next  = req.argument;
                    unique case (req.mode)
                        MODE_YIELD, MODE_CLOCK:
                        begin
                            scan_start   = 1'b1;
                            idx_next     = '0;
                            last_next    = LAST_IDX;
                            issuing_next = 1'b1;
                            st_next      = ST_SCAN;
                        end
                        MODE_EXIT:
                        begin
                            st_next = ST_EXIT_RD;
                        end
                        MODE_SET_PRIORITY, MODE_SET_SHARES:
                        begin
                            st_next = ST_SET_RD;
                        end
                        default:
                        begin
                            res_none_next = 1'b0;
                            st_next       = ST_DONE;
                        end
                    endcase
                end
            end
            ST_EXIT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
                st_next = ST_EXIT_WR;
            end
            ST_EXIT_WR:
            begin
                wr_en            = 1'b1;
                wr_addr          = cur_reg;
                wr_data.runnable = 1'b0;
                scan_start       = 1'b1;
                idx_next         = '0;
                last_next        = LAST_IDX;
                issuing_next     = 1'b1;
                st_next          = ST_SCAN;
            end
            ST_SET_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
                st_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                if (mode_reg == MODE_SET_PRIORITY)
                begin
                    wr_data.prio = arg_reg;
                end
                else
                begin
                    wr_data.share = arg_reg;
                end
                res_none_next = 1'b0;
                st_next       = ST_DONE;
            end
            ST_SCAN:
            begin
                scan_en = rd_pend_reg;
                if (last_data)
                begin
                    st_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_none_next = !flags.found;
                if (flags.found)
                begin
                    cur_next = pick_idx;
                end
                if (policy_reg == POL_SHARE && (flags.clear_all || flags.bump))
                begin
                    idx_next     = flags.clear_all ? '0 : pick_idx;
                    last_next    = flags.clear_all ? LAST_IDX : pick_idx;
                    issuing_next = 1'b1;
                    st_next      = ST_UPD;
                end
                else
                begin
                    st_next = ST_DONE;
                end
            end
            ST_UPD:
            begin
                if (rd_pend_reg)
                begin
                    wr_en = 1'b1;
                    if (flags.clear_all)
                    begin
                        // picked slot starts the new round with one
                        wr_data.count = (flags.found && rd_idx_reg == pick_idx)
                                        ? ARG_W'(1) : '0;
                    end
                    else
                    begin
                        wr_data.count = rd_data.count + ARG_W'(1);
                    end
                end
                if (last_data)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = NEXT_W'({1'b0, cur_reg} + (IDX_W + 1)'(1));
                    out_none_next  = res_none_reg;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            policy_reg    <= POL_SHARE;
            cur_reg       <= '0;
            issuing_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cur_reg       <= cur_next;
            issuing_reg   <= issuing_next;
            rd_pend_reg   <= rd_en;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                policy_reg <= policy_t'(cfg.scheduling_policy);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        arg_reg      <= arg_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        rd_idx_reg   <= rd_addr;
        res_none_reg <= res_none_next;
        out_slot_reg <= out_slot_next;
        out_none_reg <= out_none_next;
    end

    `MPPS_ASSERT_NOW(a_cur_in_range, 1'b1, cur_reg <= LAST_IDX, "current slot out of range")
    `MPPS_ASSERT_NOW(a_no_rw_overlap, rd_en && wr_en, rd_addr != wr_addr, "same-entry read and write")
    `MPPS_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, st_reg != ST_IDLE, "accept ignored")
    `MPPS_ASSERT_NOW(a_upd_share_only, st_reg == ST_UPD, policy_reg == POL_SHARE, "update pass outside share")

endmodule
